[rtl/vdf_pkg.sv]
// Package for the Vietnamese diacritic folder: item structs, letter codes
// and the code point folding functions. No dependencies.
package vdf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } vdf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } vdf_out_t;

  localparam logic [7:0] NO_LETTER = 8'h00;
  localparam logic [7:0] LETTER_A  = 8'h61;
  localparam logic [7:0] LETTER_D  = 8'h64;
  localparam logic [7:0] LETTER_E  = 8'h65;
  localparam logic [7:0] LETTER_I  = 8'h69;
  localparam logic [7:0] LETTER_O  = 8'h6F;
  localparam logic [7:0] LETTER_U  = 8'h75;
  localparam logic [7:0] LETTER_Y  = 8'h79;

  localparam logic [7:0] UPPER_FIRST = 8'h41;
  localparam logic [7:0] UPPER_LAST  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // Base letter of a code point taken from a two-byte sequence.
  function automatic logic [7:0] fold_two(input logic [10:0] cp);
    logic [7:0] r;
    unique case (cp)
      11'h0C0, 11'h0C1, 11'h0C2, 11'h0C3,
      11'h0E0, 11'h0E1, 11'h0E2, 11'h0E3,
      11'h102, 11'h103:                     r = LETTER_A;
      11'h0C8, 11'h0C9, 11'h0CA,
      11'h0E8, 11'h0E9, 11'h0EA:            r = LETTER_E;
      11'h0CC, 11'h0CD, 11'h0EC, 11'h0ED,
      11'h128, 11'h129:                     r = LETTER_I;
      11'h0D2, 11'h0D3, 11'h0D4, 11'h0D5,
      11'h0F2, 11'h0F3, 11'h0F4, 11'h0F5,
      11'h1A0, 11'h1A1:                     r = LETTER_O;
      11'h0D9, 11'h0DA, 11'h0F9, 11'h0FA,
      11'h168, 11'h169, 11'h1AF, 11'h1B0:   r = LETTER_U;
      11'h0DD, 11'h0FD:                     r = LETTER_Y;
      11'h110, 11'h111:                     r = LETTER_D;
      default:                              r = NO_LETTER;
    endcase
    return r;
  endfunction

  // Base letter of a code point taken from a three-byte sequence.
  function automatic logic [7:0] fold_three(input logic [15:0] cp);
    logic [7:0] r;
    priority if (cp >= 16'h1EA0 && cp <= 16'h1EB7) r = LETTER_A;
    else if (cp >= 16'h1EB8 && cp <= 16'h1EC7)     r = LETTER_E;
    else if (cp >= 16'h1EC8 && cp <= 16'h1ECB)     r = LETTER_I;
    else if (cp >= 16'h1ECC && cp <= 16'h1EE3)     r = LETTER_O;
    else if (cp >= 16'h1EE4 && cp <= 16'h1EF1)     r = LETTER_U;
    else if (cp >= 16'h1EF2 && cp <= 16'h1EF9)     r = LETTER_Y;
    else                                           r = NO_LETTER;
    return r;
  endfunction

endpackage

[rtl/vietnamese_diacritic_folder.sv]
// Top level of the Vietnamese diacritic folder: UTF-8 gathering, folding
// and a four-byte result shift register. Depends on vdf_pkg.
//
// The block folds a UTF-8 byte stream, one byte per transfer. Bytes of a
// multi-byte character are gathered in a small holding register; when the
// character completes, a Vietnamese vowel with any diacritic or tone mark,
// in either case, is replaced by its plain lowercase base letter, d-stroke
// becomes 'd', ASCII uppercase is lowercased and everything else is copied
// unchanged. A sequence broken by a non-continuation byte, or cut off by the
// byte marked in_last, is flushed as it was received. Each input transfer
// yields zero to four result bytes; run_last marks the last result byte of
// an input transfer and text_end marks the final result byte of the string.
// The input byte is decoded in a single combinational pass against the
// holding register and the results are loaded into a four-entry shift
// register that drains one byte per cycle while out_stall is low. The block
// sustains one byte per cycle on plain text when the output does not stall;
// a transfer that yields several bytes stalls the input until they drain,
// and the next input is taken in the cycle that its last byte leaves.
module vietnamese_diacritic_folder
  import vdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  vdf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output vdf_out_t out_data
);

  // Gathering state for the character in progress.
  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [1:0] need_r, need_nxt;

  // Result shift register: slot 0 is on the output.
  logic [7:0] res_r [4];
  logic [2:0] rem_r;
  logic       end_r;

  logic       in_xfer;
  logic       out_xfer;

  // Combinational results of the accepted byte.
  logic [7:0] o_byte [4];
  logic [2:0] o_n;

  assign out_xfer = out_valid && !out_stall;
  // The input waits while the shift register still has bytes that will not
  // all leave in this cycle.
  assign in_stall = (rem_r > 3'd1) || (rem_r == 3'd1 && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    logic [7:0]  b;
    logic        active;
    logic        do_start;
    logic [7:0]  letter;
    logic [10:0] cp2;
    logic [15:0] cp3;
    b        = in_data.in_byte;
    held_nxt = held_r;
    held_cnt_nxt = held_cnt_r;
    need_nxt = need_r;
    o_byte   = '{default: 8'h00};
    o_n      = 3'd0;
    do_start = 1'b0;
    letter   = NO_LETTER;
    cp2      = {held_r[0][4:0], b[5:0]};
    cp3      = {held_r[0][3:0], held_r[1][5:0], b[5:0]};
    active   = (need_r != 2'd0) && (held_cnt_r != 2'd0);

    if (active && b[7:6] == 2'b10) begin
      if (need_r == 2'd1 || held_cnt_r == 2'd3) begin
        // The character is complete: fold it or copy it as received.
        if (held_cnt_r == 2'd1 && cp2 >= 11'h080) begin
          letter = fold_two(cp2);
        end else if (held_cnt_r == 2'd2 && cp3 >= 16'h0800) begin
          letter = fold_three(cp3);
        end
        if (letter != NO_LETTER) begin
          o_byte[0] = letter;
          o_n       = 3'd1;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (k < int'(held_cnt_r)) begin
              o_byte[o_n[1:0]] = held_r[k];
              o_n = o_n + 3'd1;
            end
          end
          o_byte[o_n[1:0]] = b;
          o_n = o_n + 3'd1;
        end
        held_cnt_nxt = 2'd0;
        need_nxt     = 2'd0;
      end else begin
        held_nxt[held_cnt_r] = b;
        held_cnt_nxt = held_cnt_r + 2'd1;
        need_nxt     = need_r - 2'd1;
      end
    end else begin
      // A broken sequence is flushed before the byte starts afresh.
      if (active) begin
        for (int k = 0; k < 3; k++) begin
          if (k < int'(held_cnt_r)) begin
            o_byte[o_n[1:0]] = held_r[k];
            o_n = o_n + 3'd1;
          end
        end
      end
      held_cnt_nxt = 2'd0;
      need_nxt     = 2'd0;
      do_start     = 1'b1;
    end

    if (do_start) begin
      if (b[7] == 1'b0) begin
        o_byte[o_n[1:0]] = (b >= UPPER_FIRST && b <= UPPER_LAST) ? b + CASE_OFFSET : b;
        o_n = o_n + 3'd1;
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        held_nxt[0]  = b;
        held_cnt_nxt = 2'd1;
        if (b[7:5] == 3'b110) begin
          need_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          need_nxt = 2'd2;
        end else begin
          need_nxt = 2'd3;
        end
      end else begin
        // A stray continuation byte or an invalid lead byte passes through.
        o_byte[o_n[1:0]] = b;
        o_n = o_n + 3'd1;
      end
    end

    // The end of the string flushes whatever is still being gathered.
    if (in_data.in_last) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_cnt_nxt) && o_n < 3'd4) begin
          o_byte[o_n[1:0]] = held_nxt[k];
          o_n = o_n + 3'd1;
        end
      end
      held_cnt_nxt = 2'd0;
      need_nxt     = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '{default: 8'h00};
      held_cnt_r <= 2'd0;
      need_r     <= 2'd0;
      rem_r      <= 3'd0;
      end_r      <= 1'b0;
    end else begin
      if (in_xfer) begin
        held_r     <= held_nxt;
        held_cnt_r <= held_cnt_nxt;
        need_r     <= need_nxt;
      end
      if (in_xfer && o_n != 3'd0) begin
        res_r <= o_byte;
        rem_r <= o_n;
        end_r <= in_data.in_last;
      end else if (out_xfer) begin
        res_r[0] <= res_r[1];
        res_r[1] <= res_r[2];
        res_r[2] <= res_r[3];
        rem_r    <= rem_r - 3'd1;
      end
    end
  end

  assign out_valid         = (rem_r != 3'd0);
  assign out_data.out_byte = res_r[0];
  assign out_data.run_last = (rem_r == 3'd1);
  assign out_data.text_end = (rem_r == 3'd1) && end_r;

`ifndef SYNTHESIS
  a_held_needs: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |-> need_r != 2'd0)
    else $error("bytes held with no continuation expected");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.in_last |=> held_cnt_r == 2'd0)
    else $error("held bytes survive the end of the string");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_data.run_last |=> out_valid)
    else $error("result run ended before its last byte");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4)
    else $error("result count exceeds four");
`endif

endmodule
